/* sv/iwqi_pkg.sv */
// ----------------------------------------------------------------------------
// iwqi_pkg: shared codes and field widths
// Command codes and sample and index widths for the interval window query index.
// ----------------------------------------------------------------------------
package iwqi_pkg;

	localparam int SAMPLE_W = 48;
	localparam int INDEX_W  = 9;
	localparam int CMD_W    = 2;
	localparam int ROW_W    = 2;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [INDEX_W-1:0]  index_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

endpackage

/* sv/interval_window_query_index.sv */
// ----------------------------------------------------------------------------
// interval_window_query_index: per-row sorted interval table with window query
// Stable insert by start with running maximum of ends; window query by two
// binary searches; clear empties all rows.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_*      in   tuser: command; tdata: row, clip_start, clip_end, window_begin,
//               window_end
// m_*      out  tdata: first_index, end_index; tuser: status
//
// One word at a time. A clear or an invalid row goes straight to the result.
// A query runs two binary searches over the row memories, each step a read
// and then a compare; an empty window ends after the first search. An insert
// runs one binary search, shifts the entries above the insert point up one
// place, then rewrites the running maxima from the new entry to the end of
// the row. The single 48-bit comparator and the single read port of each
// memory serialise this work. Reset empties all rows at once (counts only).
// A stalled result holds in the output register; the next word is taken
// meanwhile and waits for it at the end of its own work.
module interval_window_query_index #(
	parameter int ROWS  = 4,
	parameter int DEPTH = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// row[1:0], clip_start[49:2], clip_end[97:50], window_begin[145:98],
	// window_end[193:146], zero fill
	input  logic [199:0]            s_tdata,
	// command[1:0]
	input  logic [iwqi_pkg::CMD_W-1:0] s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// first_index[8:0], end_index[17:9], zero fill
	output logic [23:0]             m_tdata,
	// status[0]
	output logic [0:0]              m_tuser
);
	import iwqi_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int MEM_N  = ROWS * DEPTH;
	localparam int ADDR_W = (MEM_N > 1) ? $clog2(MEM_N) : 1;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SRCH    = 8'b0000_0010,
		ST_CMP     = 8'b0000_0100,
		ST_SH_RD   = 8'b0000_1000,
		ST_SH_WR   = 8'b0001_0000,
		ST_PM_PREV = 8'b0010_0000,
		ST_PM_WR   = 8'b0100_0000,
		ST_DONE    = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		K_INS = 2'd0,
		K_Q1  = 2'd1,
		K_Q2  = 2'd2
	} kind_t;

	state_t state_q;
	kind_t  kind_q;

	logic [ROW_W-1:0]  row_q;
	sample_t           cs_q, ce_q, wb_q, we_q;
	logic [CNT_W-1:0]  lo_q, hi_q, n_q, i_q, first_q, mid_q;
	sample_t           prev_q;
	logic [CNT_W-1:0]  cnt_q [ROWS];
	index_t            res_first_q, res_end_q;
	logic              res_status_q;
	logic              m_tvalid_q;
	index_t            m_first_q, m_end_q;
	logic              m_status_q;

	// row memories
	sample_t starts_mem [MEM_N];
	sample_t ends_mem   [MEM_N];
	sample_t rmax_mem   [MEM_N];
	sample_t rd_start_q, rd_end_q, rd_rmax_q;

	logic [CNT_W-1:0]  rd_idx, mid_c;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [CNT_W-1:0]  wr_idx;
	logic              we_start, we_end, we_rmax;
	sample_t           wd_start, wd_end, wd_rmax;
	sample_t           cmp_a, cmp_b, pm_val, pm_max;
	logic              cmp_le;
	logic [RIDX_W-1:0] rsel, in_rsel;
	logic              in_row_ok;
	logic              in_full;
	logic              in_search;
	logic [ROW_W-1:0]  in_row;
	cmd_t              in_cmd;

	assign in_cmd    = cmd_t'(s_tuser);
	assign in_row    = s_tdata[1:0];
	assign in_row_ok = (32'(in_row) < ROWS);
	assign in_rsel   = RIDX_W'(in_row);
	assign in_full   = (32'(cnt_q[in_rsel]) >= DEPTH);
	assign in_search = in_row_ok &&
		((in_cmd == CMD_QUERY) || (in_cmd == CMD_INSERT && !in_full));
	assign rsel      = RIDX_W'(row_q);
	assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
	assign s_tready  = (state_q == ST_IDLE);

	// shared 48-bit comparator
	always_comb begin
		pm_val = (i_q == lo_q) ? ce_q : rd_end_q;
		cmp_a  = '0;
		cmp_b  = '0;
		unique case (state_q)
			ST_CMP: begin
				case (kind_q)
					K_INS:   begin cmp_a = rd_start_q; cmp_b = cs_q;       end
					K_Q1:    begin cmp_a = rd_rmax_q;  cmp_b = wb_q;       end
					default: begin cmp_a = we_q;       cmp_b = rd_start_q; end
				endcase
			end
			ST_SRCH:  begin cmp_a = we_q;   cmp_b = wb_q;   end
			ST_PM_WR: begin cmp_a = prev_q; cmp_b = pm_val; end
			default:  begin cmp_a = '0;     cmp_b = '0;     end
		endcase
		cmp_le = (cmp_a <= cmp_b);
		pm_max = cmp_le ? pm_val : prev_q;
	end

	// memory address and write control
	always_comb begin
		rd_idx   = '0;
		wr_idx   = '0;
		we_start = 1'b0;
		we_end   = 1'b0;
		we_rmax  = 1'b0;
		wd_start = rd_start_q;
		wd_end   = rd_end_q;
		wd_rmax  = pm_max;
		unique case (state_q)
			ST_SRCH: rd_idx = mid_c;
			ST_SH_RD: begin
				if (i_q > lo_q) begin
					rd_idx = i_q - 1'b1;
				end else begin
					rd_idx   = lo_q - 1'b1;
					wr_idx   = lo_q;
					we_start = 1'b1;
					we_end   = 1'b1;
					wd_start = cs_q;
					wd_end   = ce_q;
				end
			end
			ST_SH_WR: begin
				wr_idx   = i_q;
				we_start = 1'b1;
				we_end   = 1'b1;
			end
			ST_PM_WR: begin
				rd_idx  = i_q + 1'b1;
				wr_idx  = i_q;
				we_rmax = 1'b1;
			end
			default: rd_idx = '0;
		endcase
		rd_addr = ADDR_W'(row_q) * ADDR_W'(DEPTH) + ADDR_W'(rd_idx[IDX_W-1:0]);
		wr_addr = ADDR_W'(row_q) * ADDR_W'(DEPTH) + ADDR_W'(wr_idx[IDX_W-1:0]);
	end

	// write and registered read of the row memories
	always_ff @(posedge clk) begin
		if (we_start) starts_mem[wr_addr] <= wd_start;
		if (we_end)   ends_mem[wr_addr]   <= wd_end;
		if (we_rmax)  rmax_mem[wr_addr]   <= wd_rmax;
		rd_start_q <= starts_mem[rd_addr];
		rd_end_q   <= ends_mem[rd_addr];
		rd_rmax_q  <= rmax_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			for (int r = 0; r < ROWS; r++) cnt_q[r] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						row_q        <= in_row;
						cs_q         <= s_tdata[49:2];
						ce_q         <= s_tdata[97:50];
						wb_q         <= s_tdata[145:98];
						we_q         <= s_tdata[193:146];
						lo_q         <= '0;
						hi_q         <= in_row_ok ? cnt_q[in_rsel] : '0;
						n_q          <= in_row_ok ? cnt_q[in_rsel] : '0;
						kind_q       <= (in_cmd == CMD_INSERT) ? K_INS : K_Q1;
						res_first_q  <= '0;
						res_end_q    <= (in_cmd == CMD_INSERT && in_row_ok && in_full) ?
							INDEX_W'(cnt_q[in_rsel]) : '0;
						res_status_q <= (in_cmd == CMD_INSERT && (!in_row_ok || in_full)) ?
							STATUS_DROPPED : STATUS_DONE;
						state_q      <= in_search ? ST_SRCH : ST_DONE;
						// empty every row on a clear
						if (in_cmd == CMD_CLEAR) begin
							for (int r = 0; r < ROWS; r++) cnt_q[r] <= '0;
						end
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_c;
						state_q <= ST_CMP;
					end else begin
						case (kind_q)
							K_INS: begin
								i_q     <= n_q;
								state_q <= ST_SH_RD;
							end
							K_Q1: begin
								first_q <= lo_q;
								if (cmp_le) begin
									res_first_q <= INDEX_W'(lo_q);
									res_end_q   <= INDEX_W'(lo_q);
									state_q     <= ST_DONE;
								end else begin
									hi_q   <= n_q;
									kind_q <= K_Q2;
								end
							end
							default: begin
								res_first_q <= INDEX_W'(first_q);
								res_end_q   <= INDEX_W'(lo_q);
								state_q     <= ST_DONE;
							end
						endcase
					end
				end
				ST_CMP: begin
					// step right when the probed entry lies at or below the key (strictly below in the second query search)
					if ((kind_q == K_Q2) ? !cmp_le : cmp_le) lo_q <= mid_q + 1'b1;
					else hi_q <= mid_q;
					state_q <= ST_SRCH;
				end
				ST_SH_RD: begin
					if (i_q > lo_q) begin
						state_q <= ST_SH_WR;
					end else begin
						cnt_q[rsel] <= n_q + 1'b1;
						n_q         <= n_q + 1'b1;
						i_q         <= lo_q;
						prev_q      <= '0;
						state_q     <= (lo_q != '0) ? ST_PM_PREV : ST_PM_WR;
					end
				end
				ST_SH_WR: begin
					i_q     <= i_q - 1'b1;
					state_q <= ST_SH_RD;
				end
				ST_PM_PREV: begin
					prev_q  <= rd_rmax_q;
					state_q <= ST_PM_WR;
				end
				ST_PM_WR: begin
					prev_q <= pm_max;
					if (i_q + 1'b1 < n_q) begin
						i_q <= i_q + 1'b1;
					end else begin
						res_first_q <= INDEX_W'(lo_q);
						res_end_q   <= INDEX_W'(n_q);
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
			m_first_q  <= res_first_q;
			m_end_q    <= res_end_q;
			m_status_q <= res_status_q;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_end_q, m_first_q};
	assign m_tuser  = m_status_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accepting a word");
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> mid_q < hi_q && mid_q >= lo_q)
		else $error("search probe outside its range");
	a_drop_zero_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[8:0] == '0)
		else $error("dropped insert reports a position");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q[rsel]) <= DEPTH)
		else $error("row count beyond depth");

endmodule
